### rtl/record_fifo_with_byte_ring_macros.svh
// Assertion macros for the record FIFO checker.
// Has no dependencies; included by rfb_checker.sv.
`ifndef RECORD_FIFO_WITH_BYTE_RING_MACROS_SVH
`define RECORD_FIFO_WITH_BYTE_RING_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define RFB_ASSERT_IMPL(name, clock, rstn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under an active-low reset.
`define RFB_ASSERT_NEXT(name, clock, rstn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rfb_pkg.sv
// Package for the record FIFO: sizes, codes and shared record types.
// Has no dependencies; used by rfb_out_stage, record_fifo_with_byte_ring and rfb_checker.
package rfb_pkg;

    localparam int QUEUES     = 2;
    localparam int DESC_DEPTH = 8;
    localparam int BYTE_DEPTH = 32;
    localparam int TYPE_WIDTH = 32;

    localparam int Q_W   = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int DP_W  = $clog2(DESC_DEPTH);
    localparam int DF_W  = $clog2(DESC_DEPTH + 1);
    localparam int BP_W  = $clog2(BYTE_DEPTH);
    localparam int BF_W  = $clog2(BYTE_DEPTH + 1);
    localparam int CMP_W = (BF_W > 8) ? BF_W : 8;

    localparam logic [1:0] FUNC_PUSH_HDR  = 2'd0;
    localparam logic [1:0] FUNC_PUSH_BYTE = 2'd1;
    localparam logic [1:0] FUNC_POP       = 2'd2;

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_HDR  = 2'd1;
    localparam logic [1:0] KIND_BYTE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_MEMORY = 2'd1;
    localparam logic [1:0] ST_NO_DATA   = 2'd2;
    localparam logic [1:0] ST_BUSY      = 2'd3;

    typedef logic [Q_W-1:0]  qidx_t;
    typedef logic [DP_W-1:0] dptr_t;
    typedef logic [DF_W-1:0] dcnt_t;
    typedef logic [BP_W-1:0] bptr_t;
    typedef logic [BF_W-1:0] bcnt_t;

    typedef struct packed {
        logic [TYPE_WIDTH-1:0] rec_type;
        bcnt_t                 rec_len;
    } desc_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [31:0] out_type;
        logic [5:0]  out_len;
        logic [7:0]  out_byte;
        logic        last;
        logic        not_empty;
    } result_t;

endpackage

### rtl/rfb_if.sv
// Request and result channel interfaces of the record FIFO.
// Depends on rfb_pkg for nothing but sits after it in compile order.
interface rfb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        queue_sel;
    logic [31:0] attr_type;
    logic [7:0]  value_len;
    logic [7:0]  data_byte;

    modport source (output valid, func, queue_sel, attr_type, value_len, data_byte,
                    input ready);
    modport sink (input valid, func, queue_sel, attr_type, value_len, data_byte,
                  output ready);
endinterface

interface rfb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] out_type;
    logic [5:0]  out_len;
    logic [7:0]  out_byte;
    logic        last;
    logic        not_empty;

    modport source (output valid, kind, status, out_type, out_len, out_byte, last,
                    not_empty, input ready);
    modport sink (input valid, kind, status, out_type, out_len, out_byte, last,
                  not_empty, output ready);
endinterface

### rtl/rfb_out_stage.sv
// Output holding register of the record FIFO result channel.
// Depends on rfb_pkg and rfb_out_if.
module rfb_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  rfb_pkg::result_t result,
    output logic             free,
    rfb_out_if.source        res
);
    import rfb_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign free = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign res.valid     = valid_reg;
    assign res.kind      = data_reg.kind;
    assign res.status    = data_reg.status;
    assign res.out_type  = data_reg.out_type;
    assign res.out_len   = data_reg.out_len;
    assign res.out_byte  = data_reg.out_byte;
    assign res.last      = data_reg.last;
    assign res.not_empty = data_reg.not_empty;

endmodule

### rtl/record_fifo_with_byte_ring.sv
// Record FIFO with per-queue descriptor rings and byte rings; uses rfb_pkg, rfb_if, rfb_out_stage.
// A push header or push byte request is accepted in S_IDLE, then applied in S_EXEC once the output stage is free.
// A pop goes through S_READ and S_EXEC to its header result, then S_POP_BYTE for its payload bytes,
// paced by the registered reads of the descriptor and payload memories and by output stalls.
// Reset clears all pointers and the pending push and sets the free counts to full;
// memory contents stay undefined until written and are only used once committed.
module record_fifo_with_byte_ring (
    input  logic      clk,
    input  logic      rst_n,
    rfb_in_if.sink    cmd,
    rfb_out_if.source res
);
    import rfb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_READ     = 4'b0010,
        S_EXEC     = 4'b0100,
        S_POP_BYTE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]            func_reg;
    qidx_t                 q_reg;
    logic [TYPE_WIDTH-1:0] type_reg;
    logic [7:0]            len_reg;
    logic [7:0]            byte_reg;

    dptr_t desc_head_reg [QUEUES];
    dptr_t desc_head_next [QUEUES];
    dptr_t desc_tail_reg [QUEUES];
    dptr_t desc_tail_next [QUEUES];
    dcnt_t desc_free_reg [QUEUES];
    dcnt_t desc_free_next [QUEUES];
    bptr_t byte_head_reg [QUEUES];
    bptr_t byte_head_next [QUEUES];
    bptr_t byte_tail_reg [QUEUES];
    bptr_t byte_tail_next [QUEUES];
    bcnt_t byte_free_reg [QUEUES];
    bcnt_t byte_free_next [QUEUES];
    bcnt_t pending_reg, pending_next;
    qidx_t pending_q_reg, pending_q_next;
    bcnt_t count_reg, count_next;

    desc_t      desc_mem [QUEUES][DESC_DEPTH];
    logic [7:0] pay_mem [QUEUES][BYTE_DEPTH];
    desc_t      desc_rd_reg;
    logic [7:0] pay_rd_reg;

    logic              accept;
    qidx_t             sq;
    qidx_t             q_in;
    logic              desc_we;
    logic              desc_rd_en;
    logic              pay_we;
    logic              pay_rd_en;
    bptr_t             pay_rd_addr;
    desc_t             desc_wdata;
    bcnt_t             used;
    bcnt_t             rlen;
    logic [QUEUES-1:0] ne_vec;
    logic              out_free;
    logic              load;
    result_t           rsp;

    function automatic dptr_t dptr_inc(input dptr_t v);
        return (v == DP_W'(DESC_DEPTH - 1)) ? '0 : v + 1'b1;
    endfunction

    function automatic bptr_t bptr_inc(input bptr_t v);
        return (v == BP_W'(BYTE_DEPTH - 1)) ? '0 : v + 1'b1;
    endfunction

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign q_in      = (QUEUES > 1) ? Q_W'(cmd.queue_sel) : '0;
    assign sq        = (func_reg == FUNC_PUSH_BYTE) ? pending_q_reg : q_reg;

    assign desc_wdata.rec_type = type_reg;
    assign desc_wdata.rec_len  = BF_W'(len_reg);

    assign used = BF_W'(BYTE_DEPTH) - byte_free_reg[sq];
    assign rlen = (desc_rd_reg.rec_len > used) ? used : desc_rd_reg.rec_len;

    always_comb
    begin
        state_next     = state_reg;
        desc_head_next = desc_head_reg;
        desc_tail_next = desc_tail_reg;
        desc_free_next = desc_free_reg;
        byte_head_next = byte_head_reg;
        byte_tail_next = byte_tail_reg;
        byte_free_next = byte_free_reg;
        pending_next   = pending_reg;
        pending_q_next = pending_q_reg;
        count_next     = count_reg;
        desc_we        = 1'b0;
        desc_rd_en     = 1'b0;
        pay_we         = 1'b0;
        pay_rd_en      = 1'b0;
        pay_rd_addr    = byte_head_reg[sq];
        load           = 1'b0;
        rsp            = '0;
        rsp.kind       = KIND_PUSH;
        rsp.status     = ST_OK;
        rsp.last       = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.func == FUNC_POP)
                    begin
                        state_next = S_READ;
                    end
                    else if (cmd.func == FUNC_PUSH_HDR || cmd.func == FUNC_PUSH_BYTE)
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_READ:
            begin
                desc_rd_en = 1'b1;
                pay_rd_en  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    case (func_reg)
                        FUNC_PUSH_HDR:
                        begin
                            if (pending_reg != '0)
                            begin
                                rsp.status = ST_BUSY;
                            end
                            else if (desc_free_reg[sq] == '0 ||
                                     CMP_W'(len_reg) > CMP_W'(byte_free_reg[sq]))
                            begin
                                rsp.status = ST_NO_MEMORY;
                            end
                            else
                            begin
                                desc_we = 1'b1;
                                if (len_reg == '0)
                                begin
                                    desc_tail_next[sq] = dptr_inc(desc_tail_reg[sq]);
                                    if (desc_free_reg[sq] != '0)
                                    begin
                                        desc_free_next[sq] = desc_free_reg[sq] - 1'b1;
                                    end
                                end
                                else
                                begin
                                    pending_next   = BF_W'(len_reg);
                                    pending_q_next = sq;
                                end
                            end
                        end
                        FUNC_PUSH_BYTE:
                        begin
                            if (pending_reg != '0)
                            begin
                                pay_we             = 1'b1;
                                byte_tail_next[sq] = bptr_inc(byte_tail_reg[sq]);
                                if (byte_free_reg[sq] != '0)
                                begin
                                    byte_free_next[sq] = byte_free_reg[sq] - 1'b1;
                                end
                                pending_next = pending_reg - 1'b1;
                                if (pending_reg == BF_W'(1))
                                begin
                                    desc_tail_next[sq] = dptr_inc(desc_tail_reg[sq]);
                                    if (desc_free_reg[sq] != '0)
                                    begin
                                        desc_free_next[sq] = desc_free_reg[sq] - 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                rsp.status = ST_NO_DATA;
                            end
                        end
                        FUNC_POP:
                        begin
                            rsp.kind = KIND_HDR;
                            if (desc_free_reg[sq] == DF_W'(DESC_DEPTH))
                            begin
                                rsp.status = ST_NO_DATA;
                            end
                            else
                            begin
                                rsp.out_type       = 32'(desc_rd_reg.rec_type);
                                rsp.out_len        = 6'(rlen);
                                rsp.last           = (rlen == '0);
                                desc_head_next[sq] = dptr_inc(desc_head_reg[sq]);
                                desc_free_next[sq] = desc_free_reg[sq] + 1'b1;
                                if (rlen != '0)
                                begin
                                    count_next = rlen;
                                    state_next = S_POP_BYTE;
                                end
                            end
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            S_POP_BYTE:
            begin
                if (out_free)
                begin
                    load               = 1'b1;
                    rsp.kind           = KIND_BYTE;
                    rsp.out_byte       = pay_rd_reg;
                    rsp.last           = (count_reg == BF_W'(1));
                    byte_head_next[sq] = bptr_inc(byte_head_reg[sq]);
                    byte_free_next[sq] = byte_free_reg[sq] + 1'b1;
                    count_next         = count_reg - 1'b1;
                    if (count_reg == BF_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pay_rd_en   = 1'b1;
                        pay_rd_addr = bptr_inc(byte_head_reg[sq]);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        for (int i = 0; i < QUEUES; i++)
        begin
            ne_vec[i] = (desc_free_next[i] != DF_W'(DESC_DEPTH));
        end
        rsp.not_empty = ne_vec[q_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pending_reg   <= '0;
            pending_q_reg <= '0;
            count_reg     <= '0;
            for (int i = 0; i < QUEUES; i++)
            begin
                desc_head_reg[i] <= '0;
                desc_tail_reg[i] <= '0;
                desc_free_reg[i] <= DF_W'(DESC_DEPTH);
                byte_head_reg[i] <= '0;
                byte_tail_reg[i] <= '0;
                byte_free_reg[i] <= BF_W'(BYTE_DEPTH);
            end
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            pending_q_reg <= pending_q_next;
            count_reg     <= count_next;
            desc_head_reg <= desc_head_next;
            desc_tail_reg <= desc_tail_next;
            desc_free_reg <= desc_free_next;
            byte_head_reg <= byte_head_next;
            byte_tail_reg <= byte_tail_next;
            byte_free_reg <= byte_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= cmd.func;
            q_reg    <= q_in;
            type_reg <= cmd.attr_type[TYPE_WIDTH-1:0];
            len_reg  <= cmd.value_len;
            byte_reg <= cmd.data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_we)
        begin
            desc_mem[sq][desc_tail_reg[sq]] <= desc_wdata;
        end
        if (desc_rd_en)
        begin
            desc_rd_reg <= desc_mem[sq][desc_head_reg[sq]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[sq][byte_tail_reg[sq]] <= byte_reg;
        end
        if (pay_rd_en)
        begin
            pay_rd_reg <= pay_mem[sq][pay_rd_addr];
        end
    end

    rfb_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .result (rsp),
        .free   (out_free),
        .res    (res)
    );

endmodule

### rtl/rfb_checker.sv
// Port-level checker for the record FIFO result channel, with its bind statement.
// Depends on rfb_pkg and record_fifo_with_byte_ring_macros.svh.
`include "record_fifo_with_byte_ring_macros.svh"

module rfb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  res_kind,
    input logic [1:0]  res_status,
    input logic [31:0] res_out_type,
    input logic [5:0]  res_out_len,
    input logic [7:0]  res_out_byte,
    input logic        res_last,
    input logic        res_not_empty
);
    import rfb_pkg::*;

    `RFB_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable({res_kind, res_status, res_out_type, res_out_len, res_out_byte, res_last, res_not_empty}), "stalled result changed")
    `RFB_ASSERT_IMPL(a_push_single, clk, rst_n, res_valid && (res_kind == KIND_PUSH), res_last && (res_out_len == 6'd0) && (res_out_type == 32'd0), "push status is not a lone final result")
    `RFB_ASSERT_IMPL(a_pop_empty, clk, rst_n, res_valid && (res_kind == KIND_HDR) && (res_status == ST_NO_DATA), res_last && !res_not_empty && (res_out_len == 6'd0), "empty pop result is malformed")
    `RFB_ASSERT_IMPL(a_byte_ok, clk, rst_n, res_valid && (res_kind == KIND_BYTE), (res_status == ST_OK) && (res_out_type == 32'd0), "payload byte result carries bad status")

endmodule

bind record_fifo_with_byte_ring rfb_checker u_rfb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_kind      (res.kind),
    .res_status    (res.status),
    .res_out_type  (res.out_type),
    .res_out_len   (res.out_len),
    .res_out_byte  (res.out_byte),
    .res_last      (res.last),
    .res_not_empty (res.not_empty)
);
